// ===== hw/rtl/lifo_stack_with_value_removal_assert.svh =====
`ifndef LIFO_STACK_WITH_VALUE_REMOVAL_ASSERT_SVH
`define LIFO_STACK_WITH_VALUE_REMOVAL_ASSERT_SVH

`ifndef SYNTHESIS

`define LSVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsvr assertion failed");

`define LSVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsvr assertion failed");

`else

`define LSVR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define LSVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lsvr_pkg.sv =====
package lsvr_pkg;

  localparam int DATA_W      = 32;
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int DEPTH_OUT_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_RM   = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/lsvr_ram.sv =====
module lsvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lifo_stack_with_value_removal.sv =====
// LIFO stack of signed 32-bit words, STACK_DEPTH entries held in one RAM with a
// registered read. Start an operation by raising start while busy is low; each
// operation gives exactly one result, shown for one cycle with out_valid high.
// The result cannot be held off, so capture it on that cycle. Push, a flagged
// operation (full push, empty pop or remove-all) and the unused action code give
// their result in the cycle after start and busy never rises. Pop passes through
// S_POP while the registered RAM read completes. Remove-all walks the stored words
// through the single RAM read port, one per cycle, compacting in place. The output
// out_depth_after is the entry count masked to 5 bits.
`include "lifo_stack_with_value_removal_assert.svh"

module lifo_stack_with_value_removal
  import lsvr_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [STAT_W-1:0]        out_status,
  output logic [DEPTH_OUT_W-1:0]   out_depth_after
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]         scan_r, scan_nxt;
  logic [CNT_W-1:0]          kept_r, kept_nxt;
  logic [DATA_W-1:0]         key_r, key_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]         out_data_r, out_data_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [CNT_W-1:0]          out_depth_r, out_depth_nxt;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;

  logic [CNT_W-1:0]          dec_cnt;
  logic [CNT_W-1:0]          kept_new;
  logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

  lsvr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign dec_cnt = cnt_r - 1'b1;
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    kept_nxt       = kept_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    out_depth_nxt  = cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[ADDR_W-1:0];
    ram_wdata      = in_value;
    ram_raddr      = dec_cnt[ADDR_W-1:0];
    kept_new       = kept_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (action_t'(in_action))
            ACT_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == FULL_CNT) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we        = 1'b1;
                cnt_nxt       = cnt_r + 1'b1;
                out_depth_nxt = cnt_r + 1'b1;
              end
            end
            ACT_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt   = dec_cnt;
                state_nxt = S_POP;
              end
            end
            ACT_REMOVE: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_raddr = '0;
                scan_nxt  = '0;
                kept_nxt  = '0;
                key_nxt   = in_value;
                state_nxt = S_RM;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        state_nxt     = S_IDLE;
      end
      S_RM: begin
        // writes go to kept_r <= scan_r, reads run ahead at scan_r + 1
        ram_raddr = scan_r + 1'b1;
        if (ram_rdata != key_r) begin
          ram_we    = 1'b1;
          ram_waddr = kept_r[ADDR_W-1:0];
          ram_wdata = ram_rdata;
          kept_new  = kept_r + 1'b1;
        end
        kept_nxt = kept_new;
        if (CNT_W'(scan_r) == dec_cnt) begin
          cnt_nxt       = kept_new;
          out_valid_nxt = 1'b1;
          out_depth_nxt = kept_new;
          state_nxt     = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      scan_r      <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign depth_ext       = {{DEPTH_OUT_W{1'b0}}, out_depth_r};
  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_depth_after = depth_ext[DEPTH_OUT_W-1:0];

  `LSVR_ASSERT_SAME(a_valid_not_busy, clk, rst_n, out_valid, !busy)
  `LSVR_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, out_valid || busy)
  `LSVR_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= FULL_CNT)
  `LSVR_ASSERT_SAME(a_compact_behind, clk, rst_n, state_r == S_RM, kept_r <= CNT_W'(scan_r))

endmodule
